FILE: src/sshm_pkg.sv
// shared types, constants and codes for the sensor sampler health monitor
package sshm_pkg;

  localparam int NUM_CH   = 5;
  localparam int NUM_ADC  = 4;
  localparam int ACCEL_CH = 4;

  localparam logic [15:0] OUTLIER_LIMIT = 16'd320;
  localparam logic [7:0]  STALE_RUN     = 8'd20;
  localparam logic [7:0]  STUCK_RUN     = 8'd10;
  localparam logic [7:0]  FAIL_RUN      = 8'd8;
  localparam logic [7:0]  RUN_MAX       = 8'hFF;
  localparam logic [15:0] ADC_MAX       = 16'd4095;
  localparam logic [15:0] RAW_INVALID   = 16'hFFFF;

  localparam logic [15:0] NORMAL_PERIOD_RST = 16'd100;
  localparam logic [15:0] FAST_PERIOD_RST   = 16'd10;

  localparam logic signed [12:0] TEMP_MID   = 13'sd2048;
  localparam logic signed [22:0] TEMP_GAIN  = 23'sd650;
  localparam logic signed [22:0] TEMP_ROUND = 23'sd1023;
  localparam logic [18:0]        HUMID_GAIN = 19'd100;
  localparam logic [20:0]        WIND_GAIN  = 21'd500;

  // configuration register indexes
  localparam logic [1:0] REG_FAST_MODE     = 2'd0;
  localparam logic [1:0] REG_NORMAL_PERIOD = 2'd1;
  localparam logic [1:0] REG_FAST_PERIOD   = 2'd2;

  typedef enum logic [1:0] {
    H_OK    = 2'd0,
    H_STALE = 2'd1,
    H_STUCK = 2'd2,
    H_FAIL  = 2'd3
  } health_t;

  typedef struct packed {
    logic [15:0] prior_raw;
    logic [15:0] average;
    logic [7:0]  same_run;
    logic [7:0]  outlier_run;
    health_t     health;
    logic        seeded;
  } chan_state_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [11:0] temp_adc;
    logic [11:0] smoke_adc;
    logic [11:0] humid_adc;
    logic [11:0] wind_adc;
    logic [15:0] accel_sample;
    logic        accel_good;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] temp_tenths;
    logic [11:0]        smoke_level;
    logic [6:0]         humidity_pct;
    logic [8:0]         wind_tenths;
    logic [15:0]        accel_value;
    logic [1:0]         health_temp;
    logic [1:0]         health_smoke;
    logic [1:0]         health_humid;
    logic [1:0]         health_wind;
    logic [1:0]         health_accel;
  } out_item_t;

endpackage

FILE: src/sshm_sched.sv
// wrap-safe sampling period scheduler
module sshm_sched import sshm_pkg::*; (
  input  logic [31:0] time_ms,
  input  logic [15:0] period,
  input  logic [31:0] last_sample_time,
  input  logic        first_pending,
  output logic        due,
  output logic [31:0] last_sample_time_next
);

  logic [31:0] base;
  logic [31:0] elapsed;
  logic [31:0] period_w;
  logic [31:0] period_x2;

  always_comb begin
    period_w  = {16'd0, period};
    period_x2 = {15'd0, period, 1'b0};
    base      = first_pending ? (time_ms - period_w) : last_sample_time;
    elapsed   = time_ms - base;
    due       = (elapsed >= period_w);
    if (!due) begin
      last_sample_time_next = base;
    end else if (elapsed >= period_x2) begin
      // fell too far behind, restart the time base
      last_sample_time_next = time_ms;
    end else begin
      last_sample_time_next = base + period_w;
    end
  end

endmodule

FILE: src/sshm_chan.sv
// one channel update: average, run counts and health
module sshm_chan import sshm_pkg::*; (
  input  chan_state_t cur,
  input  logic [15:0] raw,
  input  logic        is_adc,
  output chan_state_t nxt
);

  logic [15:0] diff;
  logic [19:0] avg_sum;
  logic        same;
  logic        rail;
  logic [7:0]  outlier;
  logic [7:0]  same_run;
  health_t     h;

  always_comb begin
    diff    = (raw >= cur.average) ? (raw - cur.average) : (cur.average - raw);
    avg_sum = {cur.average, 4'd0} - {4'd0, cur.average} + {4'd0, raw};
    outlier = cur.outlier_run;
    nxt     = cur;
    if (!cur.seeded) begin
      nxt.average = raw;
      nxt.seeded  = 1'b1;
    end else begin
      if (is_adc) begin
        if (diff > OUTLIER_LIMIT) begin
          outlier = (cur.outlier_run == RUN_MAX) ? RUN_MAX : cur.outlier_run + 8'd1;
        end else begin
          outlier = 8'd0;
        end
      end
      nxt.average = avg_sum[19:4];
    end

    same     = (raw == cur.prior_raw);
    same_run = same ? ((cur.same_run == RUN_MAX) ? RUN_MAX : cur.same_run + 8'd1) : 8'd0;
    rail     = is_adc && ((raw == 16'd0) || (raw == ADC_MAX));

    h = same ? cur.health : H_OK;
    if (outlier >= FAIL_RUN) begin
      h = H_FAIL;
    end else if (same) begin
      if (rail && (same_run >= STUCK_RUN)) begin
        h = H_STUCK;
      end else if (!rail && (same_run >= STALE_RUN)) begin
        h = H_STALE;
      end
    end

    nxt.outlier_run = outlier;
    nxt.same_run    = same_run;
    nxt.health      = h;
    nxt.prior_raw   = raw;
  end

endmodule

FILE: src/sensor_sampler_health_monitor_unit.sv
// top level: input register, scheduler, channel updates, scaling and result register
// a due tick is held in the input register, then in the result register, before it is valid on out_item
// throughput: one tick per cycle while no due tick waits on a held result; the channel state loop is combinational
// ticks that are not due are consumed without producing a result
// rst (synchronous) restores period registers to 100/10 ms, normal mode,
// clears all channel state and re-arms the first-sample pending flag
module sensor_sampler_health_monitor_unit import sshm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic        fast_sel;
  logic [15:0] normal_period;
  logic [15:0] fast_period;

  // input register stage
  logic     in_v;
  in_item_t in_r;

  // scheduler state
  logic [31:0] last_sample_time;
  logic [31:0] last_sample_time_next;
  logic        first_pending;
  logic        due;
  logic [15:0] period;

  // per-channel state
  chan_state_t chan [NUM_CH];
  chan_state_t chan_upd [NUM_CH];
  chan_state_t chan_next [NUM_CH];
  logic [15:0] raw [NUM_CH];

  // scaling
  logic signed [12:0] temp_off;
  logic signed [22:0] temp_prod;
  logic signed [22:0] temp_adj;
  logic signed [22:0] temp_q;
  logic [18:0]        humid_prod;
  logic [20:0]        wind_prod;
  out_item_t          result;

  logic advance;

  // config writes must arrive only while idle; the block does not enforce this, and takes every write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_sel      <= 1'b0;
      normal_period <= NORMAL_PERIOD_RST;
      fast_period   <= FAST_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FAST_MODE:     fast_sel      <= cfg_data[0];
        REG_NORMAL_PERIOD: normal_period <= cfg_data;
        REG_FAST_PERIOD:   fast_period   <= cfg_data;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  assign period = fast_sel ? fast_period : normal_period;

  sshm_sched u_sched (
    .time_ms               (in_r.time_ms),
    .period                (period),
    .last_sample_time      (last_sample_time),
    .first_pending         (first_pending),
    .due                   (due),
    .last_sample_time_next (last_sample_time_next)
  );

  // the staged tick moves on when it yields nothing or the result register can take it
  assign advance  = in_v && (!due || !out_valid || out_ready);
  assign in_ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
  end

  // raw channel values widened to the state width
  always_comb begin
    raw[0]        = {4'd0, in_r.temp_adc};
    raw[1]        = {4'd0, in_r.smoke_adc};
    raw[2]        = {4'd0, in_r.humid_adc};
    raw[3]        = {4'd0, in_r.wind_adc};
    raw[ACCEL_CH] = in_r.accel_sample;
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    sshm_chan u_chan (
      .cur    (chan[k]),
      .raw    (raw[k]),
      .is_adc (k < NUM_ADC),
      .nxt    (chan_upd[k])
    );
  end

  // a failed accelerometer read overrides the normal update of that channel
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      chan_next[k] = chan_upd[k];
    end
    if (!in_r.accel_good) begin
      chan_next[ACCEL_CH].health      = H_FAIL;
      chan_next[ACCEL_CH].same_run    = 8'd0;
      chan_next[ACCEL_CH].outlier_run = 8'd0;
      chan_next[ACCEL_CH].seeded      = 1'b0;
      chan_next[ACCEL_CH].prior_raw   = RAW_INVALID;
      chan_next[ACCEL_CH].average     = 16'd0;
    end
  end

  // scheduler state commits when the staged tick is consumed, channel state only if it is also due
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= 32'd0;
      first_pending    <= 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
        chan[k] <= '0;
      end
    end else if (advance) begin
      last_sample_time <= last_sample_time_next;
      first_pending    <= 1'b0;
      if (due) begin
        for (int k = 0; k < NUM_CH; k++) begin
          chan[k] <= chan_next[k];
        end
      end
    end
  end

  // physical scaling; temperature division truncates toward zero
  always_comb begin
    temp_off   = TEMP_MID - $signed({1'b0, in_r.temp_adc});
    temp_prod  = 23'(temp_off) * TEMP_GAIN;
    temp_adj   = temp_prod + ((temp_prod < 0) ? TEMP_ROUND : 23'sd0);
    temp_q     = temp_adj >>> 10;
    humid_prod = 19'(in_r.humid_adc) * HUMID_GAIN;
    wind_prod  = 21'(in_r.wind_adc) * WIND_GAIN;

    result.temp_tenths  = temp_q[11:0];
    result.smoke_level  = in_r.smoke_adc;
    result.humidity_pct = humid_prod[18:12];
    result.wind_tenths  = wind_prod[20:12];
    result.accel_value  = in_r.accel_sample;
    result.health_temp  = chan_next[0].health;
    result.health_smoke = chan_next[1].health;
    result.health_humid = chan_next[2].health;
    result.health_wind  = chan_next[3].health;
    result.health_accel = chan_next[ACCEL_CH].health;
  end

  // result register, loaded on a due tick, held until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && due) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && due) begin
      out_item <= result;
    end
  end

endmodule
